@@ rtl/rgbhsv_pkg.sv @@
// Shared types, constants and helper functions for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int HueSector = (360 + 5) / 6;
    localparam int HueFull   = 360;
    localparam int ChanFull  = 255;
    localparam int PctFull   = 100;
    localparam int SatSteps  = 8;
    localparam int HueSteps  = 6;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic          active;
        t_sector       sector;
        logic          neg;
        logic [7:0]    mx;
        logic [7:0]    delta;
        logic [7:0]    mag;
    } t_front;

    typedef struct packed {
        logic          active;
        t_sector       sector;
        logic          neg;
        logic [7:0]    mx;
        logic [7:0]    delta;
        logic [6:0]    bright;
        logic [7:0]    rem1;
        logic [7:0]    dlow1;
        logic [7:0]    quo1;
        logic [7:0]    rem2;
        logic [5:0]    dlow2;
        logic [5:0]    quo2;
    } t_div_stage;

    // Scales 0..255 to a truncated percentage, x*100/255, by a reciprocal.
    function automatic logic [6:0] pct_of(input logic [7:0] v);
        logic [15:0] x;
        logic [15:0] y;
        x = 16'(v) * 16'(PctFull);
        y = x + 16'd1 + (x >> 8);
        return y[14:8];
    endfunction

    // One restoring step of each divider; the hue divider stops after its last bit.
    function automatic t_div_stage div_step(input t_div_stage s, input logic do_hue);
        t_div_stage  n;
        logic [8:0]  t1;
        logic [8:0]  t2;
        n  = s;
        t1 = {s.rem1, s.dlow1[7]};
        n.dlow1 = {s.dlow1[6:0], 1'b0};
        if (t1 >= {1'b0, s.mx}) begin
            n.rem1 = 8'(t1 - {1'b0, s.mx});
            n.quo1 = {s.quo1[6:0], 1'b1};
        end else begin
            n.rem1 = t1[7:0];
            n.quo1 = {s.quo1[6:0], 1'b0};
        end
        if (do_hue) begin
            t2 = {s.rem2, s.dlow2[5]};
            n.dlow2 = {s.dlow2[4:0], 1'b0};
            if (t2 >= {1'b0, s.delta}) begin
                n.rem2 = 8'(t2 - {1'b0, s.delta});
                n.quo2 = {s.quo2[4:0], 1'b1};
            end else begin
                n.rem2 = t2[7:0];
                n.quo2 = {s.quo2[4:0], 1'b0};
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/rgb_to_hsv_convert.sv @@
// Top level of the RGB to HSV converter: pipelined front end, two dividers, output stage.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per request into hue (0..359 degrees),
// saturation and brightness (0..100 percent).
// Input channel: i_valid with i_red, i_green, i_blue; a request is taken
// at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_hue, o_saturation, o_brightness; a result
// is taken at an edge where o_valid is high and i_stall is low.
// From request to result: one stage finds the largest channel, one forms
// the dividends, eight stages each retire one saturation quotient bit (the
// first six also a hue bit), and one stage scales the results.
// Throughput is one pixel per cycle while the receiver does not stall.
// Reset clears every valid bit of the pipeline.
// While the receiver stalls a waiting result, the whole pipeline holds and
// o_stall is raised, so nothing is lost or repeated.
module rgb_to_hsv_convert (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [8:0] o_hue,
    output logic [6:0] o_saturation,
    output logic [6:0] o_brightness
);
    import rgbhsv_pkg::*;

    logic       en;
    t_front     n_a;
    t_front     r_a;
    logic       r_a_vld;
    t_div_stage n_st [0:SatSteps];
    t_div_stage r_st [0:SatSteps];
    logic       r_vld [0:SatSteps];
    logic [7:0] mn;
    logic [7:0] opa;
    logic [7:0] opb;
    logic [15:0] dvd1;
    logic [13:0] dvd2;
    logic [8:0] n_hue;
    logic [6:0] n_sat;
    logic [8:0] quo2_ext;
    logic       r_out_vld;
    logic [8:0] r_hue;
    logic [6:0] r_sat;
    logic [6:0] r_bright;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    always_comb begin
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a.sector = SEC_RED;
            n_a.mx     = i_red;
            opa        = i_green;
            opb        = i_blue;
        end else if (i_green >= i_blue) begin
            n_a.sector = SEC_GREEN;
            n_a.mx     = i_green;
            opa        = i_blue;
            opb        = i_red;
        end else begin
            n_a.sector = SEC_BLUE;
            n_a.mx     = i_blue;
            opa        = i_red;
            opb        = i_green;
        end
        n_a.delta  = n_a.mx - mn;
        n_a.active = (n_a.delta != 8'd0);
        n_a.neg    = (opa < opb);
        n_a.mag    = n_a.neg ? (opb - opa) : (opa - opb);
    end

    always_comb begin
        dvd1 = 16'(r_a.delta) * 16'(ChanFull);
        dvd2 = 14'(r_a.mag) * 14'(HueSector);
        n_st[0].active = r_a.active;
        n_st[0].sector = r_a.sector;
        n_st[0].neg    = r_a.neg;
        n_st[0].mx     = r_a.mx;
        n_st[0].delta  = r_a.delta;
        n_st[0].bright = pct_of(r_a.mx);
        n_st[0].rem1   = dvd1[15:8];
        n_st[0].dlow1  = dvd1[7:0];
        n_st[0].quo1   = 8'd0;
        n_st[0].rem2   = dvd2[13:6];
        n_st[0].dlow2  = dvd2[5:0];
        n_st[0].quo2   = 6'd0;
        for (int k = 0; k < SatSteps; k++) begin
            n_st[k + 1] = div_step(r_st[k], k < HueSteps);
        end
    end

    always_comb begin
        quo2_ext = 9'(r_st[SatSteps].quo2);
        n_sat    = 7'd0;
        n_hue    = 9'd0;
        if (r_st[SatSteps].active) begin
            n_sat = pct_of(r_st[SatSteps].quo1);
            case (r_st[SatSteps].sector)
                SEC_RED: begin
                    if (r_st[SatSteps].neg && quo2_ext != 9'd0) begin
                        n_hue = 9'(HueFull) - quo2_ext;
                    end else begin
                        n_hue = quo2_ext;
                    end
                end
                SEC_GREEN: begin
                    n_hue = r_st[SatSteps].neg ? 9'(2 * HueSector) - quo2_ext
                                               : 9'(2 * HueSector) + quo2_ext;
                end
                SEC_BLUE: begin
                    n_hue = r_st[SatSteps].neg ? 9'(4 * HueSector) - quo2_ext
                                               : 9'(4 * HueSector) + quo2_ext;
                end
                default: begin
                    n_hue = 9'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= SatSteps; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_a_vld   <= i_valid;
            r_vld[0]  <= r_a_vld;
            for (int k = 0; k < SatSteps; k++) begin
                r_vld[k + 1] <= r_vld[k];
            end
            r_out_vld <= r_vld[SatSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a;
            for (int k = 0; k <= SatSteps; k++) begin
                r_st[k] <= n_st[k];
            end
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= r_st[SatSteps].bright;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

@@ tb/sv/rgb_to_hsv_convert_test.sv @@
// Self-checking testbench for rgb_to_hsv_convert: predicts hue, saturation and brightness
// for every accepted pixel and compares each result in order, under random stalls and gaps.
// Depends on rgbhsv_pkg and rgb_to_hsv_convert.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_test;

    import rgbhsv_pkg::*;

    typedef struct {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bright;
    } t_hsv;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_red        = 8'd0;
    logic [7:0] i_green      = 8'd0;
    logic [7:0] i_blue       = 8'd0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [8:0] o_hue;
    logic [6:0] o_saturation;
    logic [6:0] o_brightness;

    t_hsv pending_hsv[$];
    int   mismatch_count = 0;
    int   hold_cycles    = 0;
    bit   tx_idle        = 1'b0;
    bit   rx_idle        = 1'b0;

    rgb_to_hsv_convert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_hsv predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        t_hsv    res;
        int      rv;
        int      gv;
        int      bv;
        int      mx;
        int      mn;
        int      delta;
        int      hue;
        int      sat;
        t_sector sector;
        rv = int'(r);
        gv = int'(g);
        bv = int'(b);
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        delta = mx - mn;
        hue = 0;
        sat = 0;
        if (mx != 0 && delta != 0) begin
            sat = ((delta * ChanFull) / mx) * PctFull / ChanFull;
            if (rv == mx) sector = SEC_RED;
            else if (gv == mx) sector = SEC_GREEN;
            else sector = SEC_BLUE;
            case (sector)
                SEC_RED: begin
                    hue = ((gv - bv) * HueSector) / delta;
                end
                SEC_GREEN: begin
                    hue = HueSector * 2 + ((bv - rv) * HueSector) / delta;
                end
                default: begin
                    hue = HueSector * 4 + ((rv - gv) * HueSector) / delta;
                end
            endcase
            if (hue < 0) hue += HueFull;
        end
        res.hue    = 9'(hue);
        res.sat    = 7'(sat);
        res.bright = 7'((mx * PctFull) / ChanFull);
        return res;
    endfunction

    // Checks every result taken by the receiver against the oldest prediction.
    always @(posedge i_clk) begin
        t_hsv exp_hsv;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hsv.size() == 0) begin
                $error("unexpected result hue=%0d saturation=%0d brightness=%0d",
                       o_hue, o_saturation, o_brightness);
                mismatch_count++;
            end else begin
                exp_hsv = pending_hsv.pop_front();
                if (o_hue !== exp_hsv.hue) begin
                    $error("hue: expected %0d, actual %0d", exp_hsv.hue, o_hue);
                    mismatch_count++;
                end
                if (o_saturation !== exp_hsv.sat) begin
                    $error("saturation: expected %0d, actual %0d", exp_hsv.sat, o_saturation);
                    mismatch_count++;
                end
                if (o_brightness !== exp_hsv.bright) begin
                    $error("brightness: expected %0d, actual %0d", exp_hsv.bright,
                           o_brightness);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: random stalls per result, or one long hold when a test asks for it.
    initial begin
        int w;
        wait (i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                w = hold_cycles;
                hold_cycles = 0;
            end else begin
                w = rx_idle ? $urandom_range(0, 4) : 0;
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (o_stall);
        pending_hsv.push_back(predict_hsv(r, g, b));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        int kind;
        int base;
        kind = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case (kind)
            0: begin
                g = r;
                b = r;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            2: begin
                r = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                b = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            end
            3: begin
                base = $urandom_range(0, 250);
                r = 8'(base + $urandom_range(0, 5));
                g = 8'(base + $urandom_range(0, 5));
                b = 8'(base + $urandom_range(0, 5));
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_random(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int n = 0; n < count; n++) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_corner_pixels();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd10);
        send_pixel(8'd200, 8'd199, 8'd200);
        send_pixel(8'd10, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd10, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd253);
        send_pixel(8'd253, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd127, 8'd128, 8'd255);
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(250);
        wait_drained();
    endtask

    task automatic test_random_gaps();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int n = 0; n < 11; n++) begin
            send_random($urandom_range(60, 140));
            if (n < 10 && $urandom_range(0, 2) == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_cycles = 80;
        send_random(60);
        wait_drained();
    endtask

    task automatic test_mixed_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_random(100);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        send_random(100);
        wait_drained();
    endtask

    initial begin
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_pixels();
        test_full_rate();
        test_output_hold();
        test_random_gaps();
        test_mixed_rate();
        i_valid <= 1'b0;
        guard = 0;
        while (pending_hsv.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_hsv.size() != 0) begin
            $error("%0d results never arrived", pending_hsv.size());
            mismatch_count++;
        end
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[rgb_to_hsv_convert] OK");
        end else begin
            $display("[rgb_to_hsv_convert] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[rgb_to_hsv_convert] ERROR");
        $finish;
    end

endmodule
